[sv/bci_pkg.sv]
// Shared constants, tables and types of the complete IoU pipeline.
`default_nettype none

package bci_pkg;

   // Input coordinate format and the pre-scaling of very wide coordinates
   localparam int COORD_BITS = 16;
   localparam int PRE_SHIFT  = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
   localparam int ECB        = COORD_BITS - PRE_SHIFT;   // effective coordinate bits
   localparam int DW         = ECB + 1;                  // edge difference, signed
   localparam int SW         = ECB + 2;                  // doubled centre delta, signed
   localparam int PW         = 2 * DW;                   // product of differences
   localparam int QW         = 2 * SW;                   // squared centre delta
   localparam int UW         = PW + 2;                   // union area, signed

   // Fraction divider: floor(num * 2^FRAC / den), QB quotient bits
   localparam int DIV_W      = 2 * ECB + 6;
   localparam int FRAC       = 16;
   localparam int QB         = 19;
   localparam int LOW_W      = QB - FRAC;
   localparam int DIV_LAT    = QB + 2;

   // CORDIC arctangent
   localparam int ATAN_STEPS  = 16;
   localparam int TAB_LEN     = 24;
   localparam int NORM_MSB    = 38;
   localparam int CW          = NORM_MSB + 4;
   localparam int SH_W        = 6;
   localparam int MSB_W       = $clog2(ECB);
   localparam int ANG_W       = 23;
   localparam int HALF_PI_Q20 = 1647099;
   localparam int ATAN_LAT    = ATAN_STEPS + 4;

   localparam int ARC_TAB [TAB_LEN] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0, 0, 0
   };

   // Aspect term v = d^2 * 4/pi^2, with d in Q.20
   localparam int K_W             = 19;
   localparam int FOUR_OVER_PI2   = 424972;
   localparam int D2_W            = 2 * ANG_W - 2;
   localparam int SPLIT           = D2_W / 2;
   localparam int PH_W            = D2_W - SPLIT + K_W;

   // Q.16 quantities
   localparam int ONE_Q16  = 65536;
   localparam int CAP_Q16  = 262144;
   localparam int IOU_W    = 17;
   localparam int DIST_W   = 19;
   localparam int VW       = 19;
   localparam int DEN_W    = 20;
   localparam int PM_W     = IOU_W + VW;
   localparam int PEN_W    = PM_W - FRAC;
   localparam int RES_W    = 22;
   localparam int CIOU_W   = 16;
   localparam int PIOU_W   = 15;
   localparam int OUT_MIN  = -32768;
   localparam int OUT_MAX  = 32767;

   // Stage numbers, counted in registers from the accepting edge
   localparam int ANG_AT  = 1 + ATAN_LAT;
   localparam int V_AT    = ANG_AT + 4;
   localparam int QIO_AT  = 3 + DIV_LAT;
   localparam int IOU_AT  = QIO_AT + 1;
   localparam int JOIN_AT = ((V_AT > IOU_AT) ? V_AT : IOU_AT) + 1;
   localparam int V_DLY   = JOIN_AT - V_AT;
   localparam int I_DLY   = JOIN_AT - IOU_AT;
   localparam int DEN_AT  = JOIN_AT + 1;
   localparam int AQ_AT   = DEN_AT + DIV_LAT;
   localparam int LAT     = AQ_AT + 2;

   typedef struct packed {
      logic             ok;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic h_zero;
      logic w_zero;
      logic neg;
   } atn_flag_type;

   typedef struct packed {
      logic [IOU_W-1:0]  iou;
      logic [DIST_W-1:0] cterm;
      logic [VW-1:0]     v;
   } mix_type;

endpackage

`default_nettype wire

[sv/bci_req_if.sv]
// Request channel: two corner-form boxes per request.
`default_nettype none

interface bci_req_if import bci_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_left;
   logic signed [COORD_BITS-1:0] first_top;
   logic signed [COORD_BITS-1:0] first_right;
   logic signed [COORD_BITS-1:0] first_bottom;
   logic signed [COORD_BITS-1:0] second_left;
   logic signed [COORD_BITS-1:0] second_top;
   logic signed [COORD_BITS-1:0] second_right;
   logic signed [COORD_BITS-1:0] second_bottom;

   modport source (
      output valid, first_left, first_top, first_right, first_bottom,
      output second_left, second_top, second_right, second_bottom,
      input  ready
   );
   modport sink (
      input  valid, first_left, first_top, first_right, first_bottom,
      input  second_left, second_top, second_right, second_bottom,
      output ready
   );
endinterface

`default_nettype wire

[sv/bci_rsp_if.sv]
// Response channel: CIoU and IoU of one box pair.
`default_nettype none

interface bci_rsp_if import bci_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CIOU_W-1:0] complete_overlap;
   logic [PIOU_W-1:0]        plain_overlap;

   modport source (output valid, complete_overlap, plain_overlap, input ready);
   modport sink   (input valid, complete_overlap, plain_overlap, output ready);
endinterface

`default_nettype wire

[sv/bci_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating.
`default_nettype none

module bci_div import bci_pkg::*; (
   input  logic            clock,
   input  logic            adv,
   input  div_req_type     req,
   output logic [QB-1:0]   quo
);

   logic [DIV_W-1:0] rem_ff [QB+1];
   logic [DIV_W-1:0] den_ff [QB+1];
   logic [LOW_W-1:0] low_ff [QB+1];
   logic [QB-1:0]    quo_ff [QB+1];
   logic             ok_ff  [QB+1];
   logic             ovf_ff [QB+1];
   logic [QB-1:0]    out_ff;
   logic [DIV_W-1:0] top_in;

   assign top_in = req.num >> LOW_W;

   // quotient would need more than QB bits when num >= den * 2^LOW_W
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= top_in;
         den_ff[0] <= req.den;
         low_ff[0] <= req.num[LOW_W-1:0];
         quo_ff[0] <= '0;
         ok_ff[0]  <= req.ok;
         ovf_ff[0] <= (top_in >= req.den);
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_bit
      localparam int B = QB - 1 - k;
      logic           nb;
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      logic           ge;

      if (B >= FRAC) begin : g_num
         assign nb = low_ff[k][B-FRAC];
      end else begin : g_zero
         assign nb = 1'b0;
      end

      assign trial = {rem_ff[k], nb};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign ge    = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= low_ff[k];
            quo_ff[k+1] <= {quo_ff[k][QB-2:0], ge};
            ok_ff[k+1]  <= ok_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!ok_ff[QB]) begin
            out_ff <= '0;
         end else if (ovf_ff[QB]) begin
            out_ff <= '1;
         end else begin
            out_ff <= quo_ff[QB];
         end
      end
   end

   assign quo = out_ff;

endmodule

`default_nettype wire

[sv/bci_atan.sv]
// Pipelined CORDIC arctangent of w/h, Q.20 radians, one rotation per stage.
`default_nettype none

module bci_atan import bci_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [DW-1:0]    w,
   input  logic signed [DW-1:0]    h,
   output logic signed [ANG_W-1:0] ang
);

   atn_flag_type            flag_in;
   atn_flag_type            fa_ff, fb_ff;
   atn_flag_type            fc_ff [ATAN_STEPS+1];
   logic [ECB-1:0]          xa_in, ya_in, xa_ff, ya_ff, xb_ff, yb_ff;
   logic [ECB-1:0]          or_v;
   logic [MSB_W-1:0]        msb;
   logic [SH_W-1:0]         sh_in, sh_ff;
   logic signed [CW-1:0]    cx_ff [ATAN_STEPS+1];
   logic signed [CW-1:0]    cy_ff [ATAN_STEPS+1];
   logic signed [ANG_W-1:0] cz_ff [ATAN_STEPS+1];
   logic signed [ANG_W-1:0] zc, ang_in, ang_ff;

   // stage 1: magnitudes and special cases
   always_comb begin
      flag_in.h_zero = (h == '0);
      flag_in.w_zero = (w == '0);
      flag_in.neg    = w[DW-1] ^ h[DW-1];
      xa_in = h[DW-1] ? ECB'(-h) : ECB'(h);
      ya_in = w[DW-1] ? ECB'(-w) : ECB'(w);
   end

   // stage 2: leading one of x|y sets the normalizing shift
   always_comb begin
      or_v = xa_ff | ya_ff;
      msb  = '0;
      for (int j = 0; j < ECB; j++) begin
         if (or_v[j]) msb = MSB_W'(j);
      end
      sh_in = SH_W'(NORM_MSB) - SH_W'(msb);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff    <= flag_in;
         xa_ff    <= xa_in;
         ya_ff    <= ya_in;
         fb_ff    <= fa_ff;
         xb_ff    <= xa_ff;
         yb_ff    <= ya_ff;
         sh_ff    <= sh_in;
         // stage 3: shift up
         cx_ff[0] <= $signed(CW'(xb_ff) << sh_ff);
         cy_ff[0] <= $signed(CW'(yb_ff) << sh_ff);
         cz_ff[0] <= '0;
         fc_ff[0] <= fb_ff;
      end
   end

   for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cy_ff[i][CW-1]) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + ANG_W'(ARC_TAB[i]);
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - ANG_W'(ARC_TAB[i]);
            end
            fc_ff[i+1] <= fc_ff[i];
         end
      end
   end

   // last stage: clamp to [0, pi/2], apply sign, overrides
   always_comb begin
      zc = cz_ff[ATAN_STEPS];
      if (zc[ANG_W-1]) begin
         zc = '0;
      end else if (zc > ANG_W'(HALF_PI_Q20)) begin
         zc = ANG_W'(HALF_PI_Q20);
      end
      priority if (fc_ff[ATAN_STEPS].h_zero) begin
         ang_in = ANG_W'(HALF_PI_Q20);
      end else if (fc_ff[ATAN_STEPS].w_zero) begin
         ang_in = '0;
      end else if (fc_ff[ATAN_STEPS].neg) begin
         ang_in = -zc;
      end else begin
         ang_in = zc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) ang_ff <= ang_in;
   end

   assign ang = ang_ff;

endmodule

`default_nettype wire

[sv/bci_geom.sv]
// Box geometry: edges, areas, enclosing diagonal and centre distance.
`default_nettype none

module bci_geom import bci_pkg::*; (
   input  logic                         clock,
   input  logic                         adv,
   input  logic signed [COORD_BITS-1:0] first_left,
   input  logic signed [COORD_BITS-1:0] first_top,
   input  logic signed [COORD_BITS-1:0] first_right,
   input  logic signed [COORD_BITS-1:0] first_bottom,
   input  logic signed [COORD_BITS-1:0] second_left,
   input  logic signed [COORD_BITS-1:0] second_top,
   input  logic signed [COORD_BITS-1:0] second_right,
   input  logic signed [COORD_BITS-1:0] second_bottom,
   output logic signed [DW-1:0]         a_width,
   output logic signed [DW-1:0]         a_height,
   output logic signed [DW-1:0]         b_width,
   output logic signed [DW-1:0]         b_height,
   output div_req_type                  iou_req,
   output div_req_type                  dist_req
);

   logic signed [ECB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   logic signed [ECB-1:0] ix_lo, ix_hi, iy_lo, iy_hi, ex_lo, ex_hi, ey_lo, ey_hi;
   logic signed [DW-1:0]  iw_in, ih_in;
   logic signed [DW-1:0]  iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff, cw_ff, ch_ff;
   logic signed [SW-1:0]  dx_ff, dy_ff;
   logic signed [PW-1:0]  inter_ff, pa_ff, pb_ff, cc_ff, hh_ff;
   logic signed [QW-1:0]  dxx_ff, dyy_ff;
   logic signed [UW-1:0]  uni;
   logic [PW:0]           c2;
   logic [QW:0]           rho;
   div_req_type           iou_ff, dist_ff;

   assign ax1 = ECB'(first_left    >>> PRE_SHIFT);
   assign ay1 = ECB'(first_top     >>> PRE_SHIFT);
   assign ax2 = ECB'(first_right   >>> PRE_SHIFT);
   assign ay2 = ECB'(first_bottom  >>> PRE_SHIFT);
   assign bx1 = ECB'(second_left   >>> PRE_SHIFT);
   assign by1 = ECB'(second_top    >>> PRE_SHIFT);
   assign bx2 = ECB'(second_right  >>> PRE_SHIFT);
   assign by2 = ECB'(second_bottom >>> PRE_SHIFT);

   always_comb begin
      ix_lo = (ax1 > bx1) ? ax1 : bx1;
      ix_hi = (ax2 < bx2) ? ax2 : bx2;
      iy_lo = (ay1 > by1) ? ay1 : by1;
      iy_hi = (ay2 < by2) ? ay2 : by2;
      ex_lo = (ax1 < bx1) ? ax1 : bx1;
      ex_hi = (ax2 > bx2) ? ax2 : bx2;
      ey_lo = (ay1 < by1) ? ay1 : by1;
      ey_hi = (ay2 > by2) ? ay2 : by2;
      iw_in = DW'(ix_hi) - DW'(ix_lo);
      ih_in = DW'(iy_hi) - DW'(iy_lo);
      if (iw_in[DW-1]) iw_in = '0;
      if (ih_in[DW-1]) ih_in = '0;
   end

   always_comb begin
      uni = UW'(pa_ff) + UW'(pb_ff) - UW'(inter_ff);
      c2  = (PW+1)'($unsigned(cc_ff)) + (PW+1)'($unsigned(hh_ff));
      rho = (QW+1)'($unsigned(dxx_ff)) + (QW+1)'($unsigned(dyy_ff));
   end

   function automatic div_req_type iou_req_in();
      div_req_type r;
      r.ok  = !uni[UW-1] && (uni != '0);
      r.num = DIV_W'($unsigned(inter_ff));
      r.den = DIV_W'($unsigned(uni));
      return r;
   endfunction

   function automatic div_req_type dist_req_in();
      div_req_type r;
      r.ok  = (c2 != '0);
      r.num = DIV_W'(rho);
      r.den = DIV_W'(c2) << 2;
      return r;
   endfunction

   // three stages: differences, products, sums
   always_ff @(posedge clock) begin
      if (adv) begin
         iw_ff    <= iw_in;
         ih_ff    <= ih_in;
         aw_ff    <= DW'(ax2) - DW'(ax1);
         ah_ff    <= DW'(ay2) - DW'(ay1);
         bw_ff    <= DW'(bx2) - DW'(bx1);
         bh_ff    <= DW'(by2) - DW'(by1);
         cw_ff    <= DW'(ex_hi) - DW'(ex_lo);
         ch_ff    <= DW'(ey_hi) - DW'(ey_lo);
         dx_ff    <= SW'(bx1) + SW'(bx2) - SW'(ax1) - SW'(ax2);
         dy_ff    <= SW'(by1) + SW'(by2) - SW'(ay1) - SW'(ay2);

         inter_ff <= PW'(iw_ff) * PW'(ih_ff);
         pa_ff    <= PW'(aw_ff) * PW'(ah_ff);
         pb_ff    <= PW'(bw_ff) * PW'(bh_ff);
         cc_ff    <= PW'(cw_ff) * PW'(cw_ff);
         hh_ff    <= PW'(ch_ff) * PW'(ch_ff);
         dxx_ff   <= QW'(dx_ff) * QW'(dx_ff);
         dyy_ff   <= QW'(dy_ff) * QW'(dy_ff);

         iou_ff   <= iou_req_in();
         dist_ff  <= dist_req_in();
      end
   end

   assign a_width  = aw_ff;
   assign a_height = ah_ff;
   assign b_width  = bw_ff;
   assign b_height = bh_ff;
   assign iou_req  = iou_ff;
   assign dist_req = dist_ff;

endmodule

`default_nettype wire

[sv/box_complete_iou.sv]
// Top level of the complete IoU (CIoU) pipeline for pairs of boxes.
// Usage:
//   req_chan carries one request: two boxes in corner form, signed Q12.4.
//   rsp_chan returns complete_overlap (CIoU, signed Q2.14, saturated) and
//   plain_overlap (IoU, unsigned Q1.14), one response per request, in order.
//   Both channels use valid/ready; a transfer happens when both are high.
// Throughput: one request per clock, sustained while rsp_chan takes responses.
// Depth: LAT = 50 register stages, set by two fraction dividers
//   in series (21 stages each, one quotient bit per stage: IoU and center
//   term in parallel, then alpha) plus the 20-stage CORDIC arctangent that
//   runs beside the first divider.
// Stall: the whole pipeline advances only while the output stage is empty
//   or being taken, so req_chan.ready drops while a response waits; nothing
//   is dropped or repeated, bubbles stay in place.
// Reset: synchronous, active high; clears the stage valid bits only, the
//   block takes requests in the first cycle after reset.
`default_nettype none

module box_complete_iou import bci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bci_req_if.sink   req_chan,
   bci_rsp_if.source rsp_chan
);

   logic                    adv;
   logic [LAT:1]            vld_ff, vld_in;

   logic signed [DW-1:0]    aw, ah, bw, bh;
   div_req_type             iou_req, dist_req, alpha_req;
   logic [QB-1:0]           q_iou, q_dist, q_alpha;
   logic signed [ANG_W-1:0] ang_a, ang_b;

   logic signed [ANG_W-1:0]   d_ff;
   logic signed [2*ANG_W-1:0] d_sq;
   logic [D2_W-1:0]           d2_ff;
   logic [PH_W-1:0]           ph_ff, pl_ff;
   logic [PH_W:0]             v_sum;
   logic [VW-1:0]             v_ff;

   logic [IOU_W-1:0]  iou_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [VW-1:0]     vj_ff    [V_DLY];
   logic [IOU_W-1:0]  ij_ff    [I_DLY];
   logic [DIST_W-1:0] sj_ff    [I_DLY];

   logic [DEN_W-1:0]  den_ff;
   mix_type           mix_den_ff;
   mix_type           md_ff    [DIV_LAT];
   mix_type           mix_q;

   logic [IOU_W-1:0]  a_sat;
   logic [PM_W-1:0]   pen_full;
   logic [PEN_W-1:0]  pen_ff;
   logic [IOU_W-1:0]  iou_p_ff;
   logic [DIST_W-1:0] dist_p_ff;

   logic signed [RES_W-1:0]  res, res4;
   logic signed [CIOU_W-1:0] ciou_in, ciou_ff;
   logic [PIOU_W-1:0]        piou_ff;

   // ---- flow control: one enable for every stage ----
   assign adv            = !vld_ff[LAT] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[LAT-1:1], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---- stages 1..3: geometry ----
   bci_geom u_geom (
      .clock         (clock),
      .adv           (adv),
      .first_left    (req_chan.first_left),
      .first_top     (req_chan.first_top),
      .first_right   (req_chan.first_right),
      .first_bottom  (req_chan.first_bottom),
      .second_left   (req_chan.second_left),
      .second_top    (req_chan.second_top),
      .second_right  (req_chan.second_right),
      .second_bottom (req_chan.second_bottom),
      .a_width       (aw),
      .a_height      (ah),
      .b_width       (bw),
      .b_height      (bh),
      .iou_req       (iou_req),
      .dist_req      (dist_req)
   );

   // ---- IoU and center term: inter/union and rho2/(4*c2) ----
   bci_div u_div_iou  (.clock(clock), .adv(adv), .req(iou_req),  .quo(q_iou));
   bci_div u_div_dist (.clock(clock), .adv(adv), .req(dist_req), .quo(q_dist));

   // ---- aspect angles of both boxes ----
   bci_atan u_atan_a (.clock(clock), .adv(adv), .w(aw), .h(ah), .ang(ang_a));
   bci_atan u_atan_b (.clock(clock), .adv(adv), .w(bw), .h(bh), .ang(ang_b));

   // ---- v = d^2 * 4/pi^2 >> 44; wide product split in two halves ----
   assign d_sq  = (2*ANG_W)'(d_ff) * (2*ANG_W)'(d_ff);
   assign v_sum = (PH_W+1)'(ph_ff) + (PH_W+1)'(pl_ff >> SPLIT);

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff  <= ang_b - ang_a;
         d2_ff <= D2_W'($unsigned(d_sq));
         ph_ff <= PH_W'(d2_ff[D2_W-1:SPLIT]) * PH_W'(FOUR_OVER_PI2);
         pl_ff <= PH_W'(d2_ff[SPLIT-1:0]) * PH_W'(FOUR_OVER_PI2);
         v_ff  <= VW'(v_sum >> (D2_W - SPLIT));
      end
   end

   // ---- saturate the quotients to 1.0 and 4.0 ----
   always_ff @(posedge clock) begin
      if (adv) begin
         iou_ff  <= (q_iou > QB'(ONE_Q16)) ? IOU_W'(ONE_Q16) : IOU_W'(q_iou);
         dist_ff <= (q_dist > QB'(CAP_Q16)) ? DIST_W'(CAP_Q16) : DIST_W'(q_dist);
      end
   end

   // ---- line both branches up at the join stage ----
   always_ff @(posedge clock) begin
      if (adv) begin
         vj_ff[0] <= v_ff;
         for (int k = 1; k < V_DLY; k++) vj_ff[k] <= vj_ff[k-1];
         ij_ff[0] <= iou_ff;
         sj_ff[0] <= dist_ff;
         for (int k = 1; k < I_DLY; k++) begin
            ij_ff[k] <= ij_ff[k-1];
            sj_ff[k] <= sj_ff[k-1];
         end
      end
   end

   // ---- alpha = v / (1 - iou + v) ----
   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff           <= DEN_W'(ONE_Q16) - DEN_W'(ij_ff[I_DLY-1])
                             + DEN_W'(vj_ff[V_DLY-1]);
         mix_den_ff.iou   <= ij_ff[I_DLY-1];
         mix_den_ff.cterm <= sj_ff[I_DLY-1];
         mix_den_ff.v     <= vj_ff[V_DLY-1];
      end
   end

   always_comb begin
      alpha_req.ok  = (den_ff != '0);
      alpha_req.num = DIV_W'(mix_den_ff.v);
      alpha_req.den = DIV_W'(den_ff);
   end

   bci_div u_div_alpha (.clock(clock), .adv(adv), .req(alpha_req), .quo(q_alpha));

   // terms ride beside the alpha divider
   always_ff @(posedge clock) begin
      if (adv) begin
         md_ff[0] <= mix_den_ff;
         for (int k = 1; k < DIV_LAT; k++) md_ff[k] <= md_ff[k-1];
      end
   end

   assign mix_q = md_ff[DIV_LAT-1];

   // ---- penalty alpha * v ----
   assign a_sat    = (q_alpha > QB'(ONE_Q16)) ? IOU_W'(ONE_Q16) : IOU_W'(q_alpha);
   assign pen_full = PM_W'(a_sat) * PM_W'(mix_q.v);

   always_ff @(posedge clock) begin
      if (adv) begin
         pen_ff    <= PEN_W'(pen_full >> FRAC);
         iou_p_ff  <= mix_q.iou;
         dist_p_ff <= mix_q.cterm;
      end
   end

   // ---- CIoU = iou - dist - pen, floor to Q.14, saturate ----
   always_comb begin
      res  = $signed(RES_W'(iou_p_ff)) - $signed(RES_W'(dist_p_ff))
             - $signed(RES_W'(pen_ff));
      res4 = res >>> 2;
      priority if (res4 < RES_W'(OUT_MIN)) begin
         ciou_in = CIOU_W'(OUT_MIN);
      end else if (res4 > RES_W'(OUT_MAX)) begin
         ciou_in = CIOU_W'(OUT_MAX);
      end else begin
         ciou_in = CIOU_W'(res4);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ciou_ff <= ciou_in;
         piou_ff <= iou_p_ff[IOU_W-1:2];
      end
   end

   assign rsp_chan.valid            = vld_ff[LAT];
   assign rsp_chan.complete_overlap = ciou_ff;
   assign rsp_chan.plain_overlap    = piou_ff;

endmodule

`default_nettype wire
